// File: rtl/rdmc_pkg.sv
// Package for the drive mode controller: mode codes, command letters,
// register indexes and the structs passed between the controller modules.
// No dependencies.
`timescale 1ns / 1ps

package rdmc_pkg;

   // Drive modes, as shown on the result channel
   typedef enum logic [2:0] {
      MODE_OFF    = 3'd0,
      MODE_HALT   = 3'd1,
      MODE_FWD    = 3'd2,
      MODE_BACK   = 3'd3,
      MODE_LEFT   = 3'd4,
      MODE_RIGHT  = 3'd5,
      MODE_GRIP   = 3'd6,
      MODE_UNGRIP = 3'd7
   } mode_type;

   // Gripper action codes
   typedef enum logic [1:0] {
      GRIP_NONE  = 2'd0,
      GRIP_CLOSE = 2'd1,
      GRIP_OPEN  = 2'd2
   } grip_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_LEFT_STRAIGHT  = 2'd0,
      CSR_RIGHT_STRAIGHT = 2'd1,
      CSR_TURN_SPEED     = 2'd2,
      CSR_TURN_LIMIT     = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 23;
   localparam int SPEED_W     = 15;
   localparam int LIMIT_W     = 23;
   localparam int ANGLE_W     = 24;
   localparam int DRIVE_W     = 16;

   // Command letters (ASCII)
   localparam logic [7:0] CMD_FWD    = 8'h46;  // F
   localparam logic [7:0] CMD_BACK   = 8'h42;  // B
   localparam logic [7:0] CMD_LEFT   = 8'h4C;  // L
   localparam logic [7:0] CMD_RIGHT  = 8'h52;  // R
   localparam logic [7:0] CMD_GRIP   = 8'h47;  // G
   localparam logic [7:0] CMD_UNGRIP = 8'h55;  // U
   localparam logic [7:0] CMD_HALT   = 8'h48;  // H

   // Register reset values
   localparam logic [SPEED_W-1:0] SPEED_RESET = 15'd50;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd23040;  // 90 degrees

   typedef struct packed {
      logic [SPEED_W-1:0] left_straight;
      logic [SPEED_W-1:0] right_straight;
      logic [SPEED_W-1:0] turn_speed;
      logic [LIMIT_W-1:0] turn_limit;
   } cfg_type;

   typedef struct packed {
      logic                      button_pressed;
      logic [7:0]                command;
      logic signed [ANGLE_W-1:0] gyro_angle;
   } item_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [DRIVE_W-1:0] left_speed;
      logic signed [DRIVE_W-1:0] right_speed;
      logic signed [ANGLE_W-1:0] turn_angle;
   } state_type;

   typedef struct packed {
      mode_type                  mode;
      logic                      drive_issue;
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
      logic                      gyro_start;
      logic                      gyro_stop;
      grip_type                  gripper_action;
      logic                      command_cleared;
   } result_type;

endpackage

// File: rtl/rdmc_csr.sv
// Configuration registers of the drive mode controller.
// Depends on rdmc_pkg.
`timescale 1ns / 1ps

module rdmc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rdmc_pkg::CSR_INDEX_W-1:0] csr_addr,
   input  logic [rdmc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rdmc_pkg::cfg_type                cfg
);
   import rdmc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_straight  <= SPEED_RESET;
         cfg_ff.right_straight <= SPEED_RESET;
         cfg_ff.turn_speed     <= SPEED_RESET;
         cfg_ff.turn_limit     <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LEFT_STRAIGHT:  cfg_ff.left_straight  <= csr_wdata[SPEED_W-1:0];
            CSR_RIGHT_STRAIGHT: cfg_ff.right_straight <= csr_wdata[SPEED_W-1:0];
            CSR_TURN_SPEED:     cfg_ff.turn_speed     <= csr_wdata[SPEED_W-1:0];
            CSR_TURN_LIMIT:     cfg_ff.turn_limit     <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/rdmc_core.sv
// Mode decision logic: from the stored state, the configuration and one
// request, form the result and the next state. Depends on rdmc_pkg.
`timescale 1ns / 1ps

module rdmc_core (
   input  rdmc_pkg::cfg_type    cfg,
   input  rdmc_pkg::state_type  state,
   input  rdmc_pkg::item_type   item,
   output rdmc_pkg::state_type  state_in,
   output rdmc_pkg::result_type result
);
   import rdmc_pkg::*;

   logic signed [DRIVE_W-1:0] fwd_left;
   logic signed [DRIVE_W-1:0] fwd_right;
   logic signed [DRIVE_W-1:0] turn_spd;
   logic signed [ANGLE_W:0]   angle_ext;
   logic signed [ANGLE_W:0]   limit_ext;
   logic                      left_done;
   logic                      right_done;
   logic                      turn_done;

   assign fwd_left   = $signed({1'b0, cfg.left_straight});
   assign fwd_right  = $signed({1'b0, cfg.right_straight});
   assign turn_spd   = $signed({1'b0, cfg.turn_speed});
   assign angle_ext  = {state.turn_angle[ANGLE_W-1], state.turn_angle};
   assign limit_ext  = $signed({2'b00, cfg.turn_limit});
   assign left_done  = angle_ext >= limit_ext;
   assign right_done = angle_ext <= -limit_ext;
   assign turn_done  = (state.mode == MODE_LEFT) ? left_done : right_done;

   always_comb begin
      logic go_fwd;
      logic go_back;
      logic go_left;
      logic go_right;
      logic btn;
      logic [7:0] cmd;

      btn      = item.button_pressed;
      cmd      = item.command;
      go_fwd   = 1'b0;
      go_back  = 1'b0;
      go_left  = 1'b0;
      go_right = 1'b0;
      state_in = state;
      result   = '0;

      case (state.mode)
         MODE_OFF: begin
            if (btn) begin
               state_in.left_speed  = '0;
               state_in.right_speed = '0;
               state_in.mode        = MODE_HALT;
            end else begin
               result.drive_issue = 1'b1;
            end
         end
         MODE_HALT, MODE_GRIP, MODE_UNGRIP: begin
            if (btn) begin
               state_in.mode      = MODE_OFF;
               result.drive_issue = 1'b1;
            end else if (cmd == CMD_FWD) begin
               go_fwd = 1'b1;
            end else if (cmd == CMD_BACK) begin
               go_back = 1'b1;
            end else if (cmd == CMD_LEFT) begin
               go_left = 1'b1;
            end else if (cmd == CMD_RIGHT) begin
               go_right = 1'b1;
            end else if (cmd == CMD_GRIP && state.mode != MODE_GRIP) begin
               state_in.mode = MODE_GRIP;
            end else if (cmd == CMD_UNGRIP && state.mode != MODE_UNGRIP) begin
               state_in.mode = MODE_UNGRIP;
            end else begin
               result.drive_issue = 1'b1;
               if (state.mode == MODE_GRIP)
                  result.gripper_action = GRIP_CLOSE;
               else if (state.mode == MODE_UNGRIP)
                  result.gripper_action = GRIP_OPEN;
            end
         end
         MODE_FWD, MODE_BACK: begin
            if (btn) begin
               state_in.mode      = MODE_OFF;
               result.drive_issue = 1'b1;
            end else if (cmd == CMD_HALT) begin
               state_in.left_speed  = '0;
               state_in.right_speed = '0;
               state_in.mode        = MODE_HALT;
            end else if (cmd == CMD_FWD && state.mode == MODE_BACK) begin
               go_fwd = 1'b1;
            end else if (cmd == CMD_BACK && state.mode == MODE_FWD) begin
               go_back = 1'b1;
            end else if (cmd == CMD_LEFT) begin
               go_left = 1'b1;
            end else if (cmd == CMD_RIGHT) begin
               go_right = 1'b1;
            end else begin
               result.drive_issue = 1'b1;
               result.left_drive  = state.left_speed;
               result.right_drive = state.right_speed;
            end
         end
         MODE_LEFT, MODE_RIGHT: begin
            if (btn) begin
               state_in.mode       = MODE_OFF;
               state_in.turn_angle = '0;
               result.gyro_stop    = 1'b1;
               result.drive_issue  = 1'b1;
            end else if (turn_done || cmd == CMD_HALT) begin
               state_in.mode          = MODE_HALT;
               state_in.turn_angle    = '0;
               state_in.left_speed    = '0;
               state_in.right_speed   = '0;
               result.gyro_stop       = 1'b1;
               result.command_cleared = 1'b1;
            end else if (cmd == CMD_FWD) begin
               state_in.turn_angle = '0;
               result.gyro_stop    = 1'b1;
               go_fwd              = 1'b1;
            end else if (cmd == CMD_BACK) begin
               state_in.turn_angle = '0;
               result.gyro_stop    = 1'b1;
               go_back             = 1'b1;
            end else begin
               // steady turning tick: keep spinning, sample the gyro
               result.drive_issue  = 1'b1;
               result.left_drive   = state.left_speed;
               result.right_drive  = state.right_speed;
               state_in.turn_angle = item.gyro_angle;
            end
         end
         default: ;
      endcase

      // load wheel speeds for the mode change taken
      if (go_fwd) begin
         state_in.mode        = MODE_FWD;
         state_in.left_speed  = fwd_left;
         state_in.right_speed = fwd_right;
      end
      if (go_back) begin
         state_in.mode        = MODE_BACK;
         state_in.left_speed  = -fwd_left;
         state_in.right_speed = -fwd_right;
      end
      if (go_left) begin
         state_in.mode        = MODE_LEFT;
         state_in.left_speed  = -turn_spd;
         state_in.right_speed = turn_spd;
         state_in.turn_angle  = '0;
         result.gyro_start    = 1'b1;
      end
      if (go_right) begin
         state_in.mode        = MODE_RIGHT;
         state_in.left_speed  = turn_spd;
         state_in.right_speed = -turn_spd;
         state_in.turn_angle  = '0;
         result.gyro_start    = 1'b1;
      end

      result.mode = state_in.mode;
   end

endmodule

// File: rtl/robot_drive_mode_controller.sv
// Drive mode controller top level: request register, decision logic,
// result register. Depends on rdmc_pkg, rdmc_csr and rdmc_core.
// A request passes through the request register and then the result register
// before it is offered on the result channel. Throughput: one request per cycle
// while the result channel is not stalled; the mode state register is updated in
// the same cycle the decision logic reads it, so ticks follow back to back.
// Reset (synchronous, active high): mode off, latched speeds and turn angle
// zero, configuration registers to their defaults, both channels empty.
`timescale 1ns / 1ps

module robot_drive_mode_controller (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // button_pressed[0], command[8:1], gyro_angle[32:9], zero fill [39:33]
   input  logic [39:0]                      req_tdata,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // mode[2:0], drive_issue[3], left_drive[19:4], right_drive[35:20],
   // gyro_start[36], gyro_stop[37], gripper_action[39:38],
   // command_cleared[40], zero fill [47:41]
   output logic [47:0]                      rsp_tdata,
   // configuration write port
   input  logic                             csr_we,
   input  logic [rdmc_pkg::CSR_INDEX_W-1:0] csr_addr,
   input  logic [rdmc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rdmc_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   rdmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rdmc_core u_core (
      .cfg      (cfg),
      .state    (state_ff),
      .item     (item_ff),
      .state_in (state_in),
      .result   (result_in)
   );

   // Advance the held request into the result register whenever that
   // register is empty or is being emptied this cycle.
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   // Request register: valid bit under reset, payload without.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.button_pressed <= req_tdata[0];
         item_ff.command        <= req_tdata[8:1];
         item_ff.gyro_angle     <= $signed(req_tdata[32:9]);
      end
   end

   // Mode state: update only as a request passes through the decision logic.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= MODE_OFF;
         state_ff.left_speed  <= '0;
         state_ff.right_speed <= '0;
         state_ff.turn_angle  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: hold while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.command_cleared, rsp_ff.gripper_action,
                        rsp_ff.gyro_stop, rsp_ff.gyro_start, rsp_ff.right_drive,
                        rsp_ff.left_drive, rsp_ff.drive_issue, rsp_ff.mode};

endmodule

// File: rtl/rdmc_checker.sv
// Port-level checks on the drive mode controller result channel, with the
// bind that attaches them to the top level. Depends on rdmc_pkg.
`timescale 1ns / 1ps

module rdmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   import rdmc_pkg::*;

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // gyro integration never starts and stops on the same tick
   a_gyro: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[36] && rsp_tdata[37]))
      else $error("gyro start and stop together");

   // no drive command means zero wheel speeds
   a_idle_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[35:4] == 32'd0)
      else $error("wheel speeds without drive command");

   // a cleared command always lands in halt and stops the gyro
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[40] |-> rsp_tdata[2:0] == MODE_HALT && rsp_tdata[37])
      else $error("cleared command outside halt");

   // gripper acts only in grip or ungrip mode
   a_grip: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39:38] != GRIP_NONE |->
         rsp_tdata[2:0] == MODE_GRIP || rsp_tdata[2:0] == MODE_UNGRIP)
      else $error("gripper action outside grip modes");

endmodule

bind robot_drive_mode_controller rdmc_checker u_rdmc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
